[src/eapg_pkg.sv]
// Types, constants and the CORDIC arctangent table for the elliptical arc point generator.
// No dependencies; every other source file imports this package.
package eapg_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int ANGLE_W      = 17;
   localparam int MAX_POINTS   = 64;
   localparam int COUNT_W      = 7;
   localparam int IDX_W        = 6;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W       = 5;
   localparam int DIV_STEPS    = ANGLE_W;

   localparam logic [ANGLE_W-1:0] TURN       = ANGLE_W'(1 << ANGLE_BITS);
   localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_POINTS);
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        radius_x;
      logic [30:0]        radius_y;
      logic [16:0]        angle_from;
      logic [16:0]        angle_to;
      logic [6:0]         point_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               is_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_TRIG_INIT,
      ST_CORDIC,
      ST_TRIG_FIN,
      ST_MUL_X,
      ST_SUM_X,
      ST_MUL_Y,
      ST_SUM_Y,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              div_step;
      logic              trig_init;
      logic              cordic_step;
      logic [STEP_W-1:0] step;
      logic              trig_fin;
      logic              mul_x;
      logic              sum_x;
      logic              mul_y;
      logic              sum_y;
      logic              out_load;
      logic              is_last;
      logic              advance;
   } cmd_type;

   typedef struct packed {
      logic             req_empty;
      logic [IDX_W-1:0] last_idx;
      logic             out_free;
   } status_type;

   // Arctangent of 2^-k as a fraction of a turn, 2^32 being one turn.
   function automatic logic [31:0] atan_phase(input logic [STEP_W-1:0] k);
      logic [31:0] v;
      unique case (k)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[src/eapg_datapath.sv]
// Datapath of the arc point generator: request registers, serial divider, angle stepper,
// CORDIC unit, shared multiplier, saturating adder and the output register. Uses eapg_pkg.
module eapg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  eapg_pkg::req_type    req_data,
   output eapg_pkg::rsp_type    rsp_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  eapg_pkg::cmd_type    cmd,
   output eapg_pkg::status_type status
);
   import eapg_pkg::*;

   // Request registers.
   logic signed [31:0]  cx_ff, cy_ff;
   logic [30:0]         rx_ff, ry_ff;
   logic [ANGLE_W-1:0]  a0_ff;
   logic [IDX_W-1:0]    d_ff;

   // Divider: sweep / d, the dividend register fills with the quotient.
   logic [ANGLE_W-1:0]  div_num_ff, div_num_in;
   logic [IDX_W-1:0]    div_rem_ff, div_rem_in;

   // Point offset kept as quotient and remainder of (2*i*sweep + d) / (2*d).
   logic [ANGLE_W-1:0]  q_ff, q_in;
   logic [IDX_W:0]      r_ff, r_in;

   logic signed [33:0]  x_ff, x_in, y_ff, y_in;
   logic signed [31:0]  z_ff, z_in;
   logic [1:0]          quad_ff;

   logic [30:0]         cmag_ff, smag_ff;
   logic                cneg_ff, sneg_ff;
   logic [61:0]         prod_ff;
   logic signed [31:0]  px_ff, py_ff;

   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   // Load-time values.
   logic [ANGLE_W-1:0]  a0c, a1c, sweep;
   logic [COUNT_W-1:0]  nc;

   always_comb begin
      a0c = (req_data.angle_from > TURN) ? TURN : req_data.angle_from;
      a1c = (req_data.angle_to > TURN) ? TURN : req_data.angle_to;
      nc  = (req_data.point_count > MAX_COUNT) ? MAX_COUNT : req_data.point_count;
      if (a1c < a0c) begin
         sweep = ANGLE_W'(a1c + TURN - a0c);
      end else begin
         sweep = a1c - a0c;
      end
   end

   // One restoring division step.
   logic [IDX_W:0] trial;
   logic           ge;
   always_comb begin
      trial      = {div_rem_ff, div_num_ff[ANGLE_W-1]};
      ge         = trial >= {1'b0, d_ff};
      div_rem_in = ge ? IDX_W'(trial - {1'b0, d_ff}) : trial[IDX_W-1:0];
      div_num_in = {div_num_ff[ANGLE_W-2:0], ge};
   end

   // Offset advance: the numerator grows by 2*sweep = Q*2d + 2*rem.
   logic [IDX_W+1:0]   r_sum, two_d;
   logic [ANGLE_W-1:0] q_sum;
   always_comb begin
      two_d = {1'b0, d_ff, 1'b0};
      r_sum = {1'b0, r_ff} + {1'b0, div_rem_ff, 1'b0};
      q_sum = q_ff + div_num_ff;
      if (r_sum >= two_d) begin
         r_in = IDX_W'(0) + (IDX_W+1)'(r_sum - two_d);
         q_in = q_sum + ANGLE_W'(1);
      end else begin
         r_in = r_sum[IDX_W:0];
         q_in = q_sum;
      end
   end

   // CORDIC rotation step.
   logic signed [33:0] dx, dy;
   logic signed [31:0] at;
   always_comb begin
      dx = y_ff >>> cmd.step;
      dy = x_ff >>> cmd.step;
      at = signed'(atan_phase(cmd.step));
      if (!z_ff[31]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   logic [ANGLE_W:0] angle;
   logic [31:0]      phase;
   always_comb begin
      angle = {1'b0, a0_ff} + {1'b0, q_ff};
      phase = 32'({14'd0, angle} << (32 - ANGLE_BITS));
   end

   logic [30:0] xcl, ycl;
   always_comb begin
      if (x_ff < 0) xcl = '0;
      else if (x_ff > ONE_Q30) xcl = ONE_Q30[30:0];
      else xcl = x_ff[30:0];
      if (y_ff < 0) ycl = '0;
      else if (y_ff > ONE_Q30) ycl = ONE_Q30[30:0];
      else ycl = y_ff[30:0];
   end

   // Rounded offset and saturating sum, shared by both axes.
   logic [32:0]        off;
   logic signed [31:0] sum_c;
   logic               sum_neg;
   logic signed [33:0] sum;
   logic signed [31:0] sum_sat;
   always_comb begin
      off     = 33'((prod_ff + 62'(1) * (62'(1) << 29)) >> 30);
      sum_c   = cmd.sum_x ? cx_ff : cy_ff;
      sum_neg = cmd.sum_x ? cneg_ff : sneg_ff;
      if (sum_neg) begin
         sum = {{2{sum_c[31]}}, sum_c} - signed'({1'b0, off});
      end else begin
         sum = {{2{sum_c[31]}}, sum_c} + signed'({1'b0, off});
      end
      if (sum > 34'sd2147483647) sum_sat = 32'sh7FFFFFFF;
      else if (sum < -34'sd2147483648) sum_sat = 32'sh80000000;
      else sum_sat = sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff      <= req_data.center_x;
         cy_ff      <= req_data.center_y;
         rx_ff      <= req_data.radius_x;
         ry_ff      <= req_data.radius_y;
         a0_ff      <= a0c;
         d_ff       <= IDX_W'(nc - COUNT_W'(1));
         div_num_ff <= sweep;
         div_rem_ff <= '0;
         q_ff       <= '0;
         r_ff       <= {1'b0, IDX_W'(nc - COUNT_W'(1))};
      end
      if (cmd.div_step) begin
         div_num_ff <= div_num_in;
         div_rem_ff <= div_rem_in;
      end
      if (cmd.advance) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
      if (cmd.trig_init) begin
         quad_ff <= phase[31:30];
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= signed'({2'b00, phase[29:0]});
      end
      if (cmd.cordic_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (cmd.trig_fin) begin
         unique case (quad_ff)
            2'd0: begin cmag_ff <= xcl; cneg_ff <= 1'b0; smag_ff <= ycl; sneg_ff <= 1'b0; end
            2'd1: begin cmag_ff <= ycl; cneg_ff <= 1'b1; smag_ff <= xcl; sneg_ff <= 1'b0; end
            2'd2: begin cmag_ff <= xcl; cneg_ff <= 1'b1; smag_ff <= ycl; sneg_ff <= 1'b1; end
            default: begin
               cmag_ff <= ycl; cneg_ff <= 1'b0; smag_ff <= xcl; sneg_ff <= 1'b1;
            end
         endcase
      end
      if (cmd.mul_x) prod_ff <= 62'(rx_ff) * 62'(cmag_ff);
      if (cmd.mul_y) prod_ff <= 62'(ry_ff) * 62'(smag_ff);
      if (cmd.sum_x) px_ff <= sum_sat;
      if (cmd.sum_y) py_ff <= sum_sat;
      if (cmd.out_load) begin
         rsp_ff.point_x <= px_ff;
         rsp_ff.point_y <= py_ff;
         rsp_ff.is_last <= cmd.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_data         = rsp_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign status.req_empty = (req_data.point_count == '0);
   assign status.last_idx  = d_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

[src/eapg_ctrl.sv]
// Sequencer of the arc point generator: walks the division, then for each point the CORDIC,
// the two multiply and add steps and the hand-off to the output register. Uses eapg_pkg.
module eapg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output eapg_pkg::cmd_type    cmd,
   input  eapg_pkg::status_type status
);
   import eapg_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.step  = cnt_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               idx_in   = '0;
               // An empty request is taken and dropped.
               if (!status.req_empty) state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_TRIG_INIT;
            end
         end
         ST_TRIG_INIT: begin
            cmd.trig_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in          = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_TRIG_FIN;
         end
         ST_TRIG_FIN: begin
            cmd.trig_fin = 1'b1;
            state_in     = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_SUM_X;
         end
         ST_SUM_X: begin
            cmd.sum_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_SUM_Y;
         end
         ST_SUM_Y: begin
            cmd.sum_y = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.is_last = (idx_ff == status.last_idx);
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (idx_ff == status.last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  idx_in      = idx_ff + IDX_W'(1);
                  state_in    = ST_TRIG_INIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[src/elliptical_arc_point_generator_top.sv]
// Top level of the elliptical arc point generator.
// Depends on eapg_pkg, eapg_ctrl and eapg_datapath.
//
// A request item on the req_ channel describes an arc of an axis-aligned ellipse; the
// block answers with point_count point items, at most 64, on the rsp_ channel, counterclockwise from
// the start angle to the end angle, the last one flagged by is_last. A count of zero
// gives no items; a count of one gives the start point only.
// Both channels use valid and stall; an item moves on an edge with valid high and
// stall low. req_stall is low only while the block is idle.
// Operation: a request is accepted, then a serial division sets up the angle step.
// Each point then goes through the 30-step CORDIC unit and then one multiplier shared by
// both axes.
// Points go through one output register; when the receiver stalls, the block holds the
// next finished point until the register frees. The next request is taken as soon as
// the last point sits in the output register.
// Reset clears the sequencer and the output valid; no item is in flight afterwards.
module elliptical_arc_point_generator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eapg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eapg_pkg::rsp_type rsp_data
);
   import eapg_pkg::*;

   cmd_type    cmd;
   status_type status;

   eapg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   eapg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[tb/tb_elliptical_arc_point_generator_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for elliptical_arc_point_generator_top: arc requests in, points out.
// Depends on eapg_pkg and the block; holds its own CORDIC-based point predictor.
module tb_elliptical_arc_point_generator_top;
   import eapg_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam logic [31:0] ATAN_TAB [30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_points[$];
   int      error_count;
   int      idle_cycles;
   bit      hold_off;
   bit      req_accepted;
   int      burst_left, gap_left;

   elliptical_arc_point_generator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cosine and sine in Q30 of an angle where 65536 is one turn.
   task automatic arc_trig(input longint angle, output longint cs, output longint sn);
      logic [31:0] phase;
      longint      x, y, z, dx, dy;
      phase = 32'(angle << 16);
      x = 652032874;
      y = 0;
      z = longint'(phase[29:0]);
      for (int k = 0; k < 30; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[k]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[k]);
         end
      end
      if (x < 0) x = 0;
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      if (y < 0) y = 0;
      if (y > 64'sd1073741824) y = 64'sd1073741824;
      case (phase[31:30])
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endtask

   function automatic logic signed [31:0] offset_coord(input logic signed [31:0] center,
                                                       input logic [30:0] radius,
                                                       input longint t);
      longint mag, off, s;
      mag = longint'(radius) * (t < 0 ? -t : t);
      off = (mag + (64'sd1 << 29)) >>> 30;
      s = (t < 0) ? longint'(center) - off : longint'(center) + off;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   task automatic predict_arc_points(input req_type r);
      longint  a0, a1, n, sweep, d, offs, cs, sn;
      rsp_type p;
      a0 = r.angle_from > 65536 ? 65536 : r.angle_from;
      a1 = r.angle_to > 65536 ? 65536 : r.angle_to;
      n = r.point_count > MAX_POINTS ? MAX_POINTS : r.point_count;
      sweep = (a1 < a0) ? a1 + 65536 - a0 : a1 - a0;
      d = n - 1;
      for (longint i = 0; i < n; i++) begin
         offs = (d == 0) ? 0 : (2 * i * sweep + d) / (2 * d);
         arc_trig(a0 + offs, cs, sn);
         p.point_x = offset_coord(r.center_x, r.radius_x, cs);
         p.point_y = offset_coord(r.center_y, r.radius_y, sn);
         p.is_last = (i == d);
         expected_points.push_back(p);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic req_type random_arc(input bit wide);
      req_type r;
      r.center_x = $urandom;
      r.center_y = $urandom;
      if (wide) begin
         r.radius_x = 31'($urandom);
         r.radius_y = 31'($urandom);
      end else begin
         r.radius_x = 31'($urandom_range(0, 32'h00FF_FFFF));
         r.radius_y = 31'($urandom_range(0, 32'h00FF_FFFF));
         r.center_x = r.center_x >>> 4;
         r.center_y = r.center_y >>> 4;
      end
      r.angle_from = ($urandom_range(0, 15) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      r.angle_to   = ($urandom_range(0, 15) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      case ($urandom_range(0, 19))
         0: r.point_count = 7'($urandom_range(65, 127));
         1: r.point_count = 7'($urandom_range(33, 64));
         2: r.point_count = 0;
         default: r.point_count = 7'($urandom_range(1, 8));
      endcase
      return r;
   endfunction

   // The driver needs to know whether the offered item was taken at the last rising edge.
   always @(posedge clock) begin
      req_accepted <= req_valid && !req_stall;
   end

   // Driver: bursts of items with random gaps; valid is held while stalled.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // Hold the offered item.
      end else begin
         if (req_valid) void'(pending_reqs.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 6);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off stretch.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else case ($urandom_range(0, 3))
         0: rsp_stall <= ($urandom_range(0, 1) == 1);
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         default: rsp_stall <= 1'b0;
      endcase
   end

   initial begin
      hold_off = 1'b0;
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_off = 1'b1;
      repeat (2000) @(posedge clock);
      hold_off = 1'b0;
   end

   // Monitor, checker and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_valid && !req_stall) begin
            predict_arc_points(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report_mismatch("point with none expected");
            end else begin
               if (rsp_data.point_x !== expected_points[0].point_x)
                  report_mismatch($sformatf("point_x %h expected %h", rsp_data.point_x,
                                            expected_points[0].point_x));
               if (rsp_data.point_y !== expected_points[0].point_y)
                  report_mismatch($sformatf("point_y %h expected %h", rsp_data.point_y,
                                            expected_points[0].point_y));
               if (rsp_data.is_last !== expected_points[0].is_last)
                  report_mismatch($sformatf("is_last %b expected %b", rsp_data.is_last,
                                            expected_points[0].is_last));
               void'(expected_points.pop_front());
            end
         end
         if (idle_cycles > IDLE_LIMIT) begin
            $display("elliptical_arc_point_generator_top test failed");
            $finish;
         end
      end
   end

   initial begin
      req_type r;
      error_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      gap_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_data = '0;

      // Directed arcs: extremes, zero and single counts, wrap, equal angles, oversize fields.
      r = '0; r.point_count = 0; pending_reqs.push_back(r);
      r.point_count = 1; r.radius_x = 31'h7FFFFFFF; r.radius_y = 31'h7FFFFFFF;
      r.center_x = 32'sh7FFFFFFF; r.center_y = 32'sh80000000; r.angle_from = 17'd0;
      pending_reqs.push_back(r);
      r.point_count = 5; r.angle_from = 17'd0; r.angle_to = 17'd65536;
      pending_reqs.push_back(r);
      r.center_x = 32'sh80000000; r.center_y = 32'sh7FFFFFFF; r.angle_from = 17'd49152;
      r.angle_to = 17'd16384; r.point_count = 7; pending_reqs.push_back(r);
      r.center_x = 0; r.center_y = 0; r.radius_x = 31'h00010000; r.radius_y = 31'h00020000;
      r.angle_from = 17'd1000; r.angle_to = 17'd1000; r.point_count = 3; pending_reqs.push_back(r);
      r.angle_from = 17'h1FFFF; r.angle_to = 17'h1FFFF; r.point_count = 7'h7F;
      pending_reqs.push_back(r);
      r.angle_from = 17'd65535; r.angle_to = 17'd0; r.point_count = 64; pending_reqs.push_back(r);
      r.angle_from = 17'd8192; r.angle_to = 17'd8191; r.point_count = 2; pending_reqs.push_back(r);
      r.angle_from = 17'd0; r.angle_to = 17'd32768; r.point_count = 65; pending_reqs.push_back(r);
      r.radius_x = 0; r.radius_y = 0; r.center_x = 32'sh12345678; r.point_count = 2;
      pending_reqs.push_back(r);
      for (int i = 0; i < 150; i++) pending_reqs.push_back(random_arc($urandom_range(0, 3) == 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_points.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("elliptical_arc_point_generator_top test passed");
      else $display("elliptical_arc_point_generator_top test failed");
      $finish;
   end
endmodule
